// File: design/gtsd_pkg.sv
`default_nettype none
package gtsd_pkg;
    localparam int COORD_W = 24;
    localparam int DIST_W = 25;
    localparam int NUM_W = 4;
    localparam int CNT_W = 5;
    localparam int SUM_W = 51;
    localparam int MAX_SENSORS_DEF = 16;
    localparam int MAX_OUT = 16;
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int ROOT_STEPS = 26;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    // One square root step carried between cells.
    typedef struct packed {
        logic            valid;
        logic            last;
        logic [NUM_W-1:0] num;
        logic [53:0]     rem;
        logic [DIST_W:0] root;
    } t_step;
endpackage
`default_nettype wire

// File: design/grid_to_sensor_distances.sv
`default_nettype none
// Channel | Dir | Fields
// s_axis  | in  | tuser: operation; tdata: mic_index, pos_x, pos_y, pos_z
// m_axis  | out | tdata: sensor_number, distance; tlast: last
// cfg     | in  | mic_count
// A load writes one table entry. A query is accepted once the previous one has
// issued, then issues one sensor per cycle unless stalled (mic_count sensors,
// 0 read as 1, capped at MAX_SENSORS and 16) into the square-root row of 26 cells.
// The whole row halts while the output register is full and not taken.
// Reset is synchronous, active low; mic_count resets to 1.
module grid_to_sensor_distances #(
    parameter int MAX_SENSORS = gtsd_pkg::MAX_SENSORS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic        s_axis_tuser,  // operation
    input  wire logic [79:0] s_axis_tdata,  // mic_index, pos_x, pos_y, pos_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // sensor_number, distance
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data
);
    import gtsd_pkg::*;
    localparam int AW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int LIM = (MAX_SENSORS < MAX_OUT) ? MAX_SENSORS : MAX_OUT;

    t_point r_mem [MAX_SENSORS];
    t_point r_grid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_issue;
    logic [CNT_W-1:0] r_total;
    logic             r_busy;
    logic [CNT_W-1:0] w_cnt;
    logic             w_en;
    logic             w_in_acc;
    logic             w_op;
    logic [NUM_W-1:0] w_idx;
    t_point           w_pos;
    t_point           r_sens;
    logic             r_sq_v, r_sq_last;
    logic [NUM_W-1:0] r_sq_num;
    logic [47:0]      r_sqx, r_sqy, r_sqz;
    logic             r_rd_v, r_rd_last;
    logic [NUM_W-1:0] r_rd_num;
    t_step            w_chain [ROOT_STEPS+1];
    logic [DIST_W-1:0] r_dist;
    logic [NUM_W-1:0]  r_onum;
    logic              r_olast, r_ov;

    assign w_op = s_axis_tuser;
    assign w_idx = s_axis_tdata[3:0];
    assign w_pos.x = s_axis_tdata[27:4];
    assign w_pos.y = s_axis_tdata[51:28];
    assign w_pos.z = s_axis_tdata[75:52];
    assign w_en = !r_ov || m_axis_tready;
    assign s_axis_tready = !r_busy && w_en;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_cnt = r_count;
        if (w_cnt == '0) w_cnt = CNT_W'(1);
        if (w_cnt > CNT_W'(LIM)) w_cnt = CNT_W'(LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_op == OP_LOAD && 32'(w_idx) < MAX_SENSORS) begin
            r_mem[AW'(w_idx)] <= w_pos;
        end
    end

    // Issue sequencer reads one table entry per cycle while the output is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
        end else if (w_en) begin
            r_rd_v <= 1'b0;
            if (w_in_acc && w_op == OP_QUERY) begin
                r_busy <= 1'b1;
                r_grid <= w_pos;
                r_issue <= '0;
                r_total <= w_cnt;
            end else if (r_busy) begin
                r_rd_v <= 1'b1;
                r_rd_num <= r_issue[NUM_W-1:0];
                r_rd_last <= (r_issue + 1'b1 == r_total);
                r_sens <= r_mem[AW'(r_issue)];
                r_issue <= r_issue + 1'b1;
                if (r_issue + 1'b1 == r_total) r_busy <= 1'b0;
            end
        end
    end

    function automatic logic [47:0] sq(input logic signed [COORD_W-1:0] a,
                                       input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        logic [COORD_W-1:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        return 48'(m) * 48'(m);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (w_en) begin
            r_sq_v <= r_rd_v;
            r_sq_num <= r_rd_num;
            r_sq_last <= r_rd_last;
            r_sqx <= sq(r_grid.x, r_sens.x);
            r_sqy <= sq(r_grid.y, r_sens.y);
            r_sqz <= sq(r_grid.z, r_sens.z);
        end
    end

    assign w_chain[0].valid = r_sq_v;
    assign w_chain[0].last = r_sq_last;
    assign w_chain[0].num = r_sq_num;
    assign w_chain[0].rem = 54'(r_sqx) + 54'(r_sqy) + 54'(r_sqz);
    assign w_chain[0].root = '0;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_cell
        gtsd_sqrt_cell #(.STEP(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_step(w_chain[g]), .o_step(w_chain[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_chain[ROOT_STEPS].valid;
            r_dist <= w_chain[ROOT_STEPS].root[DIST_W-1:0];
            r_onum <= w_chain[ROOT_STEPS].num;
            r_olast <= w_chain[ROOT_STEPS].last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {3'd0, r_dist, r_onum};
    assign m_axis_tlast = r_olast;

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_dist))
        else $error("output word changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !s_axis_tready)
        else $error("input accepted during issue");
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_issue < r_total)
        else $error("issue count past total");
`endif
endmodule
`default_nettype wire

// File: design/gtsd_sqrt_cell.sv
`default_nettype none
module gtsd_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire gtsd_pkg::t_step  i_step,
    output gtsd_pkg::t_step       o_step
);
    import gtsd_pkg::*;

    // Restoring digit step: try (root<<2|1) against the remainder shifted down to the current bit pair.
    localparam int SH = 2 * (ROOT_STEPS - 1 - STEP);
    t_step r_step;
    t_step n_step;
    logic [53:0] w_trial;
    logic [53:0] w_top;

    always_comb begin
        n_step = i_step;
        w_top = i_step.rem >> SH;
        w_trial = {26'd0, i_step.root, 2'b01};
        if (w_top >= w_trial) begin
            n_step.rem = i_step.rem - (w_trial << SH);
            n_step.root = {i_step.root[DIST_W-1:0], 1'b1};
        end else begin
            n_step.root = {i_step.root[DIST_W-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step.valid <= 1'b0;
        end else if (i_en) begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;
endmodule
`default_nettype wire
